@@ rtl/core/mlcar_pkg.sv @@
// constants, widths and codes for the multi load cell converter reader
// no dependencies; imported by multi_load_cell_adc_reader_top
package mlcar_pkg;

   localparam int MAX_CHANNELS = 4;
   localparam int SAMPLE_BITS  = 24;
   localparam int VALUE_BITS   = 24;
   localparam int COUNT_BITS   = 16;
   localparam int CHCNT_BITS   = 3;
   localparam int PHASE_BITS   = 6;
   localparam int ACTION_BITS  = 2;
   localparam int PINS_BITS    = 4;

   // last step of a read: 2*SAMPLE_BITS+2
   localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(2 * SAMPLE_BITS + 2);

   localparam logic [CHCNT_BITS-1:0] CHCNT_RESET = CHCNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] POLL_RESET  = COUNT_BITS'(625);

   // request kinds carried in tuser
   localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_STOP  = 2'd2;

   // register indexes on the csr port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLL_INTERVAL = 2'd1;

   // stream word sizes
   localparam int REQ_DATA_BITS = 24;   // pins + read count, padded to bytes
   localparam int RSP_FIELD_BITS = 1 + MAX_CHANNELS * VALUE_BITS + COUNT_BITS + 1;
   localparam int RSP_DATA_BITS = 120;  // rsp fields padded to bytes
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_FIELD_BITS;

endpackage

@@ rtl/core/multi_load_cell_adc_reader_top.sv @@
// top level of the multi load cell converter reader: burst control, poll timer,
// shared serial clock, bit capture and result word register; uses mlcar_pkg
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  req     | in  | req_tvalid/tready   | tuser: action; tdata: pins, read count
//  rsp     | out | rsp_tvalid/tready   | tuser: sample_valid; tdata: sck, values,
//          |     |                     |        reads_left, busy_res
//  csr     | in  | csr_valid/ready     | csr_index, csr_data (always ready)
//
// one request word gives one response word; a word is taken whenever req_tready is
// high, and its response is registered in the output register in the cycle after
// throughput is one word per cycle while rsp is not stalled, set by the single registered update step
// reset (synchronous, active high) clears burst, read and clock state and loads
// channel_count = 1, poll_interval = 625
// when rsp is stalled with a word held, req_tready drops until that word leaves
module multi_load_cell_adc_reader_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [3:0] dout_pins, [19:4] read_count, [23:20] zero
   input  logic [mlcar_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // [1:0] action
   input  logic [mlcar_pkg::ACTION_BITS-1:0]      req_tuser,
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] sck, [24:1] value0, [48:25] value1, [72:49] value2, [96:73] value3,
   // [112:97] reads_left, [113] busy_res, [119:114] zero
   output logic [mlcar_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // [0] sample_valid
   output logic                                   rsp_tuser,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mlcar_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mlcar_pkg::COUNT_BITS-1:0]       csr_data
);
   import mlcar_pkg::*;

   // configuration registers
   logic [CHCNT_BITS-1:0]  chcnt_ff;
   logic [COUNT_BITS-1:0]  poll_ff;

   // reader state
   logic                   burst_ff, burst_in;
   logic [COUNT_BITS-1:0]  remain_ff, remain_in;
   logic [COUNT_BITS-1:0]  countdown_ff, countdown_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [SAMPLE_BITS-1:0] shift_ff [MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0] shift_in [MAX_CHANNELS];
   logic                   sck_ff, sck_in;

   // output word register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;

   // request fields
   logic [ACTION_BITS-1:0] action;
   logic [PINS_BITS-1:0]   pins;
   logic [COUNT_BITS-1:0]  count;

   logic                   req_accept;
   logic [MAX_CHANNELS-1:0] active_mask;
   logic [COUNT_BITS-1:0]  interval_eff;
   logic                   lines_ready;
   logic [VALUE_BITS-1:0]  vals [MAX_CHANNELS];

   assign action = req_tuser;
   assign pins   = req_tdata[PINS_BITS-1:0];
   assign count  = req_tdata[PINS_BITS +: COUNT_BITS];

   // output register frees up whenever its word is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // channel counts above the maximum act as the maximum
   always_comb begin
      for (int j = 0; j < MAX_CHANNELS; j++) begin
         active_mask[j] = (32'(chcnt_ff) > j);
      end
   end

   // zero interval behaves as one
   assign interval_eff = (poll_ff == '0) ? COUNT_BITS'(1) : poll_ff;

   // ready when every active data line is low
   assign lines_ready = ((pins & active_mask) == '0);

   always_comb begin
      burst_in     = burst_ff;
      remain_in    = remain_ff;
      countdown_in = countdown_ff;
      phase_in     = phase_ff;
      sck_in       = sck_ff;
      rsp_user_in  = 1'b0;
      for (int j = 0; j < MAX_CHANNELS; j++) begin
         shift_in[j] = shift_ff[j];
         vals[j]     = '0;
      end

      case (action)
         ACT_START: begin
            remain_in    = count;
            burst_in     = (count != '0);
            countdown_in = interval_eff;
            phase_in     = '0;
            sck_in       = 1'b0;
         end
         ACT_STOP: begin
            burst_in  = 1'b0;
            remain_in = '0;
            phase_in  = '0;
            sck_in    = 1'b0;
         end
         ACT_TICK: begin
            if (burst_ff) begin
               if (phase_ff == '0) begin
                  // polling for data ready
                  if (countdown_ff > COUNT_BITS'(1)) begin
                     countdown_in = countdown_ff - COUNT_BITS'(1);
                  end else if (lines_ready) begin
                     for (int j = 0; j < MAX_CHANNELS; j++) begin
                        shift_in[j] = '0;
                     end
                     phase_in = PHASE_BITS'(1);
                     sck_in   = 1'b0;
                  end else begin
                     countdown_in = interval_eff;
                  end
               end else if (phase_ff[0]) begin
                  // odd step: from step 3 on, capture after the falling edge; then raise sck
                  if (phase_ff >= PHASE_BITS'(3)) begin
                     for (int j = 0; j < MAX_CHANNELS; j++) begin
                        shift_in[j] = {shift_ff[j][SAMPLE_BITS-2:0],
                                       pins[j] & active_mask[j]};
                     end
                  end
                  sck_in   = 1'b1;
                  phase_in = phase_ff + PHASE_BITS'(1);
               end else begin
                  // even step: drop sck; last one ends the read
                  sck_in = 1'b0;
                  if (phase_ff >= LAST_PHASE) begin
                     rsp_user_in = 1'b1;
                     for (int j = 0; j < MAX_CHANNELS; j++) begin
                        if (active_mask[j]) begin
                           vals[j] = VALUE_BITS'(shift_ff[j]);
                        end
                     end
                     if (remain_ff > '0) begin
                        remain_in = remain_ff - COUNT_BITS'(1);
                     end
                     if (remain_in == '0) begin
                        burst_in = 1'b0;
                     end
                     phase_in     = '0;
                     countdown_in = interval_eff;
                  end else begin
                     phase_in = phase_ff + PHASE_BITS'(1);
                  end
               end
            end
         end
         default: begin
            // unused code: state holds, levels reported as they are
         end
      endcase

      rsp_data_in = {{RSP_PAD_BITS{1'b0}}, burst_in, remain_in,
                     vals[3], vals[2], vals[1], vals[0], sck_in};
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chcnt_ff <= CHCNT_RESET;
         poll_ff  <= POLL_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CHANNEL_COUNT) begin
            chcnt_ff <= csr_data[CHCNT_BITS-1:0];
         end else if (csr_index == CSR_POLL_INTERVAL) begin
            poll_ff <= csr_data;
         end
      end
   end

   // reader state advances on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff     <= 1'b0;
         remain_ff    <= '0;
         countdown_ff <= '0;
         phase_ff     <= '0;
         sck_ff       <= 1'b0;
         for (int j = 0; j < MAX_CHANNELS; j++) begin
            shift_ff[j] <= '0;
         end
      end else if (req_accept) begin
         burst_ff     <= burst_in;
         remain_ff    <= remain_in;
         countdown_ff <= countdown_in;
         phase_ff     <= phase_in;
         sck_ff       <= sck_in;
         for (int j = 0; j < MAX_CHANNELS; j++) begin
            shift_ff[j] <= shift_in[j];
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

endmodule
